// ===== hw/rtl/nps_pkg.sv =====
// ----------------------------------------------------------------------------
// nps_pkg: shared types and constants of the nearest point search
// Field widths, action codes, register address, the control state type and
// the tag that travels with each stored point through the distance pipeline.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int COORD_W  = 24;   // Q8.16 coordinate
  localparam int DIFF_W   = COORD_W + 1;
  localparam int SQ_W     = 2 * COORD_W + 1;  // square of a difference
  localparam int DIST_W   = 50;   // sum of three squares, Q18.32
  localparam int INDEX_W  = 12;
  localparam int COUNT_W  = 13;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

  // Register index, taken from paddr bit 2 (registers are 4 bytes apart)
  localparam logic REG_POINT_COUNT = 1'b0;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } nps_state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } nps_point_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } nps_tag_t;

endpackage

// ===== hw/rtl/nearest_point_search.sv =====
// ----------------------------------------------------------------------------
// nearest_point_search: brute-force 3-D nearest neighbor over a point store
// Input channel (in_valid_i / in_stall_o) carries load and query items. A
// load writes one point into the store in the cycle it is accepted and gives
// no result. A query walks store slots 0 .. point_count-1, one slot per cycle
// through the single store read port, and returns the nearest slot and its
// squared distance on the output channel (out_valid_o / out_stall_i); the
// lowest index wins a tie. A point_count of zero searches slot 0 only, and a
// count above MAX_POINTS searches the whole store.
// Timing: a query holds in_stall_o high through the scan, then the store
// read, three distance stages, the compare and the hand-off to the output
// register. out_valid_o rises as in_stall_o drops, so the next item can be
// taken in the same cycle; a query is not taken while an earlier one is in
// flight. If the receiver stalls, the result holds in the output register; a
// further query finishes its scan and waits, input stalled, for the register.
// Reset returns point_count to 4096 and empties the pipeline; the store is
// not cleared, so a query must only cover loaded slots. Write point_count
// over the APB-style port (byte address 0) only while the block is idle.
// ----------------------------------------------------------------------------
module nearest_point_search #(
  parameter int MAX_POINTS = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              action_i,
  input  logic [nps_pkg::INDEX_W-1:0]       point_index_i,
  input  logic signed [nps_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [nps_pkg::COORD_W-1:0] coord_y_i,
  input  logic signed [nps_pkg::COORD_W-1:0] coord_z_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [nps_pkg::INDEX_W-1:0]       match_index_o,
  output logic [nps_pkg::DIST_W-1:0]        match_dist_o,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nps_pkg::APB_AW-1:0]        paddr,
  input  logic [nps_pkg::APB_DW-1:0]        pwdata,
  output logic [nps_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW = (AW + 1 > nps_pkg::COUNT_W) ? AW + 1 : nps_pkg::COUNT_W;
  localparam logic [NW-1:0] MAXP = NW'(MAX_POINTS);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [nps_pkg::COUNT_W-1:0] point_count_q;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == nps_pkg::REG_POINT_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= nps_pkg::COUNT_RESET;
    end else if (cfg_wr) begin
      point_count_q <= pwdata[nps_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == nps_pkg::REG_POINT_COUNT) begin
      prdata = nps_pkg::APB_DW'(point_count_q);
    end
  end

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  nps_pkg::nps_state_e state_q, state_d;
  logic [AW-1:0]       rd_addr_q, rd_addr_d;
  logic [AW-1:0]       last_addr_q, last_addr_d;
  logic [AW-1:0]       cmp_idx_q, cmp_idx_d;
  logic [AW-1:0]       best_idx_q, best_idx_d;
  logic [nps_pkg::DIST_W-1:0] best_dist_q, best_dist_d;
  nps_pkg::nps_point_t query_q;
  logic                out_valid_q, out_valid_d;
  logic [nps_pkg::INDEX_W-1:0] out_index_q;
  logic [nps_pkg::DIST_W-1:0]  out_dist_q;

  logic                in_acc;
  logic                load_acc;
  logic                query_acc;
  logic                out_free;
  logic                emit;
  logic [NW-1:0]       count_ext;
  nps_pkg::nps_tag_t   tag0, tag1_q, tag_s;
  logic [nps_pkg::DIST_W-1:0] dist_s;
  logic [AW-1:0]       cur_idx;
  logic                better;

  assign in_stall_o = (state_q != nps_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_acc   = in_acc && (action_i == nps_pkg::ACT_LOAD);
  assign query_acc  = in_acc && (action_i == nps_pkg::ACT_QUERY);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign count_ext  = NW'(point_count_q);

  // last slot to visit: zero count searches slot 0, large count saturates
  always_comb begin
    if (count_ext == '0) begin
      last_addr_d = '0;
    end else if (count_ext > MAXP) begin
      last_addr_d = AW'(MAXP - NW'(1));
    end else begin
      last_addr_d = AW'(count_ext - NW'(1));
    end
  end

  // issue tag for the slot read this cycle
  always_comb begin
    tag0       = '0;
    tag0.vld   = (state_q == nps_pkg::ST_SCAN);
    tag0.first = (rd_addr_q == '0);
    tag0.last  = (rd_addr_q == last_addr_q);
  end

  // running minimum over the distance stream; strict compare keeps the
  // lowest index on a tie
  assign cur_idx = tag_s.first ? '0 : cmp_idx_q;
  assign better  = tag_s.first || (dist_s < best_dist_q);

  always_comb begin
    cmp_idx_d   = cmp_idx_q;
    best_idx_d  = best_idx_q;
    best_dist_d = best_dist_q;
    if (tag_s.vld) begin
      cmp_idx_d = cur_idx + AW'(1);
      if (better) begin
        best_idx_d  = cur_idx;
        best_dist_d = dist_s;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    rd_addr_d = rd_addr_q;
    emit      = 1'b0;
    unique case (state_q)
      nps_pkg::ST_IDLE: begin
        if (query_acc) begin
          rd_addr_d = '0;
          state_d   = nps_pkg::ST_SCAN;
        end
      end
      nps_pkg::ST_SCAN: begin
        rd_addr_d = rd_addr_q + AW'(1);
        if (tag0.last) begin
          state_d = nps_pkg::ST_DRAIN;
        end
      end
      nps_pkg::ST_DRAIN: begin
        // wait for the last distance to reach the compare
        if (tag_s.vld && tag_s.last) begin
          state_d = nps_pkg::ST_EMIT;
        end
      end
      nps_pkg::ST_EMIT: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = nps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = nps_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && out_stall_i) || emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nps_pkg::ST_IDLE;
      rd_addr_q   <= '0;
      cmp_idx_q   <= '0;
      out_valid_q <= 1'b0;
      tag1_q      <= '0;
    end else begin
      state_q     <= state_d;
      rd_addr_q   <= rd_addr_d;
      cmp_idx_q   <= cmp_idx_d;
      out_valid_q <= out_valid_d;
      tag1_q      <= tag0;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q  <= best_idx_d;
    best_dist_q <= best_dist_d;
    if (query_acc) begin
      query_q.x   <= coord_x_i;
      query_q.y   <= coord_y_i;
      query_q.z   <= coord_z_i;
      last_addr_q <= last_addr_d;
    end
    if (emit) begin
      out_index_q <= nps_pkg::INDEX_W'(best_idx_q);
      out_dist_q  <= best_dist_q;
    end
  end

  // --------------------------------------------------------------------------
  // Point store: one write port used by loads in IDLE, one registered read
  // port used by the scan. Loads and scans never overlap, so no forwarding.
  // --------------------------------------------------------------------------
  nps_pkg::nps_point_t store_mem [MAX_POINTS];
  nps_pkg::nps_point_t rd_data_q;
  logic                wr_en;

  // drop loads aimed beyond the store
  assign wr_en = load_acc && (32'(point_index_i) < 32'(MAX_POINTS));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[AW'(point_index_i)] <= {coord_x_i, coord_y_i, coord_z_i};
    end
    rd_data_q <= store_mem[rd_addr_q];
  end

  nps_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (tag1_q),
    .query_i (query_q),
    .point_i (rd_data_q),
    .tag_o   (tag_s),
    .dist_o  (dist_s)
  );

  assign out_valid_o   = out_valid_q;
  assign match_index_o = out_index_q;
  assign match_dist_o  = out_dist_q;

endmodule

// ===== hw/rtl/nps_dist.sv =====
// ----------------------------------------------------------------------------
// nps_dist: squared distance pipeline
// Three stages: coordinate differences, squares, sum. The tag moves in step
// with the data so that the consumer knows where a scan starts and ends.
// ----------------------------------------------------------------------------
module nps_dist (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  nps_pkg::nps_tag_t                tag_i,
  input  nps_pkg::nps_point_t              query_i,
  input  nps_pkg::nps_point_t              point_i,
  output nps_pkg::nps_tag_t                tag_o,
  output logic [nps_pkg::DIST_W-1:0]       dist_o
);

  localparam int DW = nps_pkg::DIFF_W;
  localparam int SW = nps_pkg::SQ_W;

  nps_pkg::nps_tag_t tag1_q, tag2_q, tag3_q;

  logic signed [DW-1:0] dx_d, dy_d, dz_d;
  logic signed [DW-1:0] dx_q, dy_q, dz_q;
  logic signed [2*DW-1:0] px, py, pz;
  logic [SW-1:0] sx_q, sy_q, sz_q;
  logic [nps_pkg::DIST_W-1:0] sum_d, sum_q;

  assign dx_d = DW'(query_i.x) - DW'(point_i.x);
  assign dy_d = DW'(query_i.y) - DW'(point_i.y);
  assign dz_d = DW'(query_i.z) - DW'(point_i.z);

  assign px = dx_q * dx_q;
  assign py = dy_q * dy_q;
  assign pz = dz_q * dz_q;

  assign sum_d = nps_pkg::DIST_W'(sx_q) + nps_pkg::DIST_W'(sy_q)
               + nps_pkg::DIST_W'(sz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    dz_q  <= dz_d;
    sx_q  <= SW'(px);
    sy_q  <= SW'(py);
    sz_q  <= SW'(pz);
    sum_q <= sum_d;
  end

  assign tag_o  = tag3_q;
  assign dist_o = sum_q;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the nearest point search
// Drives load and query items with random gaps and output stalls, and keeps
// its own copy of the point store and of point_count. Every accepted query is
// answered here by an exhaustive nearest-slot search. Each result is checked
// field by field against the oldest pending answer. The register is written
// and read back over the APB-style port, but only while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import nps_pkg::*;

  localparam int STORE_DEPTH    = 4096;
  localparam int FILL_SLOTS     = 48;     // low slots loaded before random use
  localparam int SETTLE_CYCLES  = 16;     // loads are written when accepted
  localparam int WATCHDOG_LIMIT = 20000;  // far above the long output hold
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASES         = 7;
  localparam int PHASE_ITEMS    = 9;

  localparam logic [APB_AW-1:0] ADDR_POINT_COUNT = {1'b0, REG_POINT_COUNT, 2'b00};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] ONE       = 24'sh010000;  // 1.0 in Q8.16

  typedef struct {
    logic [INDEX_W-1:0] slot;
    logic [DIST_W-1:0]  sq_distance;
  } match_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       action_i = ACT_LOAD;
  logic [INDEX_W-1:0]         point_index_i = '0;
  logic signed [COORD_W-1:0]  coord_x_i = '0;
  logic signed [COORD_W-1:0]  coord_y_i = '0;
  logic signed [COORD_W-1:0]  coord_z_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [INDEX_W-1:0]         match_index_o;
  logic [DIST_W-1:0]          match_dist_o;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [APB_AW-1:0]          paddr = '0;
  logic [APB_DW-1:0]          pwdata = '0;
  logic [APB_DW-1:0]          prdata;
  logic                       pready;

  // Shadow state of the block
  nps_point_t                 store_pts [STORE_DEPTH];
  logic [COUNT_W-1:0]         count_cfg = COUNT_RESET;
  match_t                     pending_matches [$];

  // Traffic shaping knobs, percent of cycles spent idle
  int unsigned                sender_idle_pct = 30;
  int unsigned                recv_idle_pct = 30;
  int                         hold_requests = 0;

  int                         mismatches = 0;
  int                         loads_sent = 0;
  int                         queries_sent = 0;
  int                         results_checked = 0;
  int                         count_settings = 0;

  nearest_point_search #(
    .MAX_POINTS(STORE_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .point_index_i(point_index_i),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .coord_z_i    (coord_z_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .match_index_o(match_index_o),
    .match_dist_o (match_dist_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Nearest-slot predictor
  // --------------------------------------------------------------------------

  // Clamp the register the way the block does: zero searches slot 0 only,
  // anything past the store depth searches the whole store.
  function automatic int searched_slots();
    if (count_cfg == '0) return 1;
    if (int'(count_cfg) > STORE_DEPTH) return STORE_DEPTH;
    return int'(count_cfg);
  endfunction

  // Exact squared distance; three 48-bit squares fit easily in a longint.
  function automatic longint sq_distance(nps_point_t a, nps_point_t b);
    longint dx, dy, dz;
    dx = longint'($signed(a.x)) - longint'($signed(b.x));
    dy = longint'($signed(a.y)) - longint'($signed(b.y));
    dz = longint'($signed(a.z)) - longint'($signed(b.z));
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic match_t nearest_match(nps_point_t q);
    match_t best;
    longint best_d, d;
    int     n;
    n = searched_slots();
    best_d = 0;
    best.slot = '0;
    for (int i = 0; i < n; i++) begin
      d = sq_distance(q, store_pts[i]);
      // strict compare keeps the lowest slot on a tie
      if (i == 0 || d < best_d) begin
        best_d = d;
        best.slot = INDEX_W'(i);
      end
    end
    best.sq_distance = DIST_W'(best_d);
    return best;
  endfunction

  // Advance the shadow state by one accepted item.
  task automatic apply_item(input logic act, input logic [INDEX_W-1:0] slot,
                            input nps_point_t p);
    if (act == ACT_LOAD) begin
      store_pts[slot] = p;
      loads_sent++;
    end else begin
      pending_matches.push_back(nearest_match(p));
      queries_sent++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one item and hold it until accepted. Valid stays high on return, so
  // a following item goes out back to back; callers drop it via wait_idle.
  task automatic send_item(input logic act, input logic [INDEX_W-1:0] slot,
                           input nps_point_t p);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    point_index_i <= slot;
    coord_x_i     <= p.x;
    coord_y_i     <= p.y;
    coord_z_i     <= p.z;
    do @(posedge clk_i); while (in_stall_o);
    apply_item(act, slot, p);
  endtask

  // Drop valid, wait for every pending result, then let trailing loads settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------

  // A setup phase, an access phase held until pready, then a bus-idle phase so
  // the next transfer never touches psel twice in one step.
  task automatic apb_transfer(input logic wr, input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_POINT_COUNT;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_point_count(input logic [COUNT_W-1:0] want);
    logic [APB_DW-1:0] rdata;
    apb_transfer(1'b0, '0, rdata);
    if (rdata !== APB_DW'(want)) begin
      $display("%0t: point_count readback expected %0d got %0d", $time, want, rdata);
      mismatches++;
    end
  endtask

  // Only call while idle.
  task automatic set_point_count(input int unsigned value);
    logic [APB_DW-1:0] rdata;
    apb_transfer(1'b1, APB_DW'(value), rdata);
    count_cfg = COUNT_W'(value);
    count_settings++;
    read_point_count(count_cfg);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic nps_point_t rand_point();
    nps_point_t p;
    p.x = rand_coord();
    p.y = rand_coord();
    p.z = rand_coord();
    return p;
  endfunction

  // A stored point nudged by up to three LSBs per axis; at times exact, which
  // gives zero distances and ties.
  function automatic nps_point_t near_point(int slot);
    nps_point_t p;
    p = store_pts[slot];
    p.x = p.x + COORD_W'(int'($urandom_range(6)) - 3);
    p.y = p.y + COORD_W'(int'($urandom_range(6)) - 3);
    p.z = p.z + COORD_W'(int'($urandom_range(6)) - 3);
    return p;
  endfunction

  function automatic nps_point_t mk_point(logic signed [COORD_W-1:0] x,
                                          logic signed [COORD_W-1:0] y,
                                          logic signed [COORD_W-1:0] z);
    nps_point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_register_reset();
    read_point_count(COUNT_RESET);
  endtask

  // One-slot search against the corners of the coordinate range.
  task automatic test_coordinate_extremes();
    wait_idle();
    set_point_count(1);
    send_item(ACT_LOAD, 12'd0, mk_point(COORD_MAX, COORD_MAX, COORD_MAX));
    send_item(ACT_QUERY, '0, mk_point(COORD_MIN, COORD_MIN, COORD_MIN));  // largest distance
    send_item(ACT_QUERY, '1, mk_point(COORD_MAX, COORD_MAX, COORD_MAX));  // zero distance
    send_item(ACT_LOAD, 12'd0, mk_point(COORD_MIN, '0, -24'sd1));
    send_item(ACT_QUERY, '0, mk_point('0, COORD_MAX, 24'sd1));
    send_item(ACT_QUERY, '0, mk_point(COORD_MAX, COORD_MIN, COORD_MIN));
  endtask

  // A zero count must search slot 0 alone, even with a better match in slot 1.
  task automatic test_zero_count();
    wait_idle();
    set_point_count(0);
    send_item(ACT_LOAD, 12'd0, mk_point(ONE, ONE, ONE));
    send_item(ACT_LOAD, 12'd1, mk_point('0, '0, '0));
    send_item(ACT_LOAD, '1, mk_point(COORD_MIN, COORD_MAX, '0));
    send_item(ACT_QUERY, '0, mk_point('0, '0, '0));
  endtask

  // Equal distances: the lowest slot has to win.
  task automatic test_tie_break();
    nps_point_t far_pt;
    wait_idle();
    set_point_count(8);
    far_pt = mk_point(COORD_W'(5 * ONE), COORD_W'(5 * ONE), COORD_W'(5 * ONE));
    send_item(ACT_LOAD, 12'd0, mk_point(COORD_W'(4 * ONE), '0, '0));
    send_item(ACT_LOAD, 12'd1, mk_point('0, COORD_W'(4 * ONE), '0));
    send_item(ACT_LOAD, 12'd2, far_pt);
    send_item(ACT_LOAD, 12'd3, mk_point(ONE, '0, '0));
    send_item(ACT_LOAD, 12'd4, mk_point('0, -ONE, '0));
    send_item(ACT_LOAD, 12'd5, far_pt);
    send_item(ACT_LOAD, 12'd6, mk_point('0, '0, COORD_W'(-3 * ONE)));
    send_item(ACT_LOAD, 12'd7, mk_point(COORD_W'(-2 * ONE), COORD_W'(-2 * ONE),
                                        COORD_W'(-2 * ONE)));
    send_item(ACT_QUERY, '0, far_pt);                  // slots 2 and 5 at zero
    send_item(ACT_QUERY, '0, mk_point('0, '0, '0));    // slots 3 and 4 at 1.0
  endtask

  // Fill the low slots back to back with no idling on either side, then
  // search all of them.
  task automatic test_fill_and_search();
    wait_idle();
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    set_point_count(FILL_SLOTS);
    for (int i = 0; i < FILL_SLOTS; i++)
      send_item(ACT_LOAD, INDEX_W'(i), rand_point());
    send_item(ACT_QUERY, '0, near_point($urandom_range(FILL_SLOTS - 1)));
    send_item(ACT_QUERY, '0, rand_point());
    send_item(ACT_QUERY, '0, near_point(FILL_SLOTS - 1));
    sender_idle_pct = 30;
    recv_idle_pct   = 30;
  endtask

  // Random phases: a fresh count each phase, mostly small, then a mix of
  // loads (often copies of stored points) and queries, some near stored points.
  task automatic test_random_phases();
    int unsigned        r;
    logic [INDEX_W-1:0] slot;
    nps_point_t         p;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      r = $urandom_range(99);
      if (r < 6) begin
        set_point_count(0);
      end else if (r < 70) begin
        set_point_count($urandom_range(16, 1));
      end else begin
        set_point_count($urandom_range(FILL_SLOTS, 17));
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(99) < 25) begin
          if ($urandom_range(1) == 0) slot = INDEX_W'($urandom_range(searched_slots() - 1));
          else slot = INDEX_W'($urandom);
          if ($urandom_range(99) < 40) p = store_pts[$urandom_range(FILL_SLOTS - 1)];
          else p = rand_point();
          send_item(ACT_LOAD, slot, p);
        end else begin
          if ($urandom_range(99) < 45) p = near_point($urandom_range(searched_slots() - 1));
          else p = rand_point();
          send_item(ACT_QUERY, INDEX_W'($urandom), p);  // index is don't-care here
        end
      end
    end
  endtask

  // Hold the output off for a long stretch while queries keep coming, so the
  // output register and the scan both fill and the input stalls.
  task automatic test_output_backpressure();
    wait_idle();
    set_point_count(3);
    sender_idle_pct = 0;
    hold_requests++;
    for (int k = 0; k < 8; k++)
      send_item(ACT_QUERY, '0, near_point($urandom_range(2)));
    sender_idle_pct = 30;
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stalls plus requested long holds
  // --------------------------------------------------------------------------
  int hold_served = 0;
  int hold_left   = 0;

  always @(posedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest pending answer.
  always @(posedge clk_i) begin
    match_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_matches.size() == 0) begin
        $display("%0t: unexpected result, expected none, got index %0d distance %0d",
                 $time, match_index_o, match_dist_o);
        mismatches++;
      end else begin
        want = pending_matches.pop_front();
        results_checked++;
        if (match_index_o !== want.slot) begin
          $display("%0t: match_index expected %0d got %0d", $time, want.slot,
                   match_index_o);
          mismatches++;
        end
        if (match_dist_o !== want.sq_distance) begin
          $display("%0t: match_dist expected %0d got %0d", $time, want.sq_distance,
                   match_dist_o);
          mismatches++;
        end
      end
    end
  end

  // Abort when nothing moves on any port for far longer than any scan or hold.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: timeout with %0d results pending", $time, pending_matches.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_reset();
    test_coordinate_extremes();
    test_zero_count();
    test_tie_break();
    test_fill_and_search();
    test_random_phases();
    test_output_backpressure();
    wait_idle();

    $display("Covered %0d loads and %0d queries over %0d point_count settings, %0d checked,",
             loads_sent, queries_sent, count_settings, results_checked);
    $display("with ties, zero counts, range corners, a gapless fill and a long output hold");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/nps_pkg.sv
hw/rtl/nps_dist.sv
hw/rtl/nearest_point_search.sv
tb/tb_top.sv
